### rtl/spo_pkg.sv
// Shared types for the shape pair overlap test.
// Holds the test opcode and the classified request passed from front to back.
// No dependencies.
package spo_pkg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RR,
        OP_RC,
        OP_CC,
        OP_RY,
        OP_CY
    } t_op;

    localparam logic [1:0] KIND_RECT   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_RAY    = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a0;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] a3;
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] b3;
    } t_item;

endpackage

### rtl/spo_front.sv
// Front end: classifies a shape pair into a test and orders the shapes.
// Depends on spo_pkg.
module spo_front import spo_pkg::*; (
    input  logic        [1:0]  i_kind_a,
    input  logic signed [31:0] i_a_p0,
    input  logic signed [31:0] i_a_p1,
    input  logic signed [31:0] i_a_p2,
    input  logic signed [31:0] i_a_p3,
    input  logic        [1:0]  i_kind_b,
    input  logic signed [31:0] i_b_p0,
    input  logic signed [31:0] i_b_p1,
    input  logic signed [31:0] i_b_p2,
    input  logic signed [31:0] i_b_p3,
    output t_item              o_item
);

    logic swap;
    t_op  op;

    always_comb begin
        swap = 1'b0;
        op   = OP_NONE;
        unique case ({i_kind_a, i_kind_b})
            {KIND_RECT, KIND_RECT}:     op = OP_RR;
            {KIND_RECT, KIND_CIRCLE}:   op = OP_RC;
            {KIND_RECT, KIND_RAY}:      op = OP_RY;
            {KIND_CIRCLE, KIND_RECT}: begin
                op = OP_RC; swap = 1'b1;
            end
            {KIND_CIRCLE, KIND_CIRCLE}: op = OP_CC;
            {KIND_CIRCLE, KIND_RAY}:    op = OP_CY;
            {KIND_RAY, KIND_RECT}: begin
                op = OP_RY; swap = 1'b1;
            end
            {KIND_RAY, KIND_CIRCLE}: begin
                op = OP_CY; swap = 1'b1;
            end
            default:                    op = OP_NONE;
        endcase
    end

    always_comb begin
        o_item.op = op;
        if (swap) begin
            o_item.a0 = i_b_p0; o_item.a1 = i_b_p1; o_item.a2 = i_b_p2; o_item.a3 = i_b_p3;
            o_item.b0 = i_a_p0; o_item.b1 = i_a_p1; o_item.b2 = i_a_p2; o_item.b3 = i_a_p3;
        end else begin
            o_item.a0 = i_a_p0; o_item.a1 = i_a_p1; o_item.a2 = i_a_p2; o_item.a3 = i_a_p3;
            o_item.b0 = i_b_p0; o_item.b1 = i_b_p1; o_item.b2 = i_b_p2; o_item.b3 = i_b_p3;
        end
    end

endmodule

### rtl/spo_fifo.sv
// Request queue between front and back end.
// Depends on spo_pkg for the request type and depth.
module spo_fifo import spo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_AW:0]     r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### rtl/spo_back.sv
// Back end: pipelined intersection arithmetic and output register.
// Depends on spo_pkg; takes classified requests from spo_fifo.
module spo_back import spo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output logic  o_hit
);

    logic en;
    logic [6:1] r_v;
    logic r_out_v;
    t_op  r1_op, r2_op, r3_op, r4_op, r5_op, r6_op;

    assign en    = !r_out_v || i_ready;
    assign o_pop = en && !i_empty;

    // stage 1: sums and differences
    logic signed [32:0] n1_axw, n1_ayh, n1_bxw, n1_byh;
    logic signed [32:0] r1_axw, r1_ayh, r1_d0, r1_d1, r1_rsum;
    logic signed [33:0] r1_n2x, r1_n2y;
    logic signed [31:0] r1_a0, r1_a1, r1_a2, r1_b0, r1_b1, r1_b2, r1_b3;
    logic               r1_rr;

    assign n1_axw = 33'(i_item.a0) + 33'(i_item.a2);
    assign n1_ayh = 33'(i_item.a1) + 33'(i_item.a3);
    assign n1_bxw = 33'(i_item.b0) + 33'(i_item.b2);
    assign n1_byh = 33'(i_item.b1) + 33'(i_item.b3);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= i_item.op;
            r1_axw  <= n1_axw;
            r1_ayh  <= n1_ayh;
            r1_d0   <= 33'(i_item.a0) - 33'(i_item.b0);
            r1_d1   <= 33'(i_item.a1) - 33'(i_item.b1);
            r1_rsum <= 33'(i_item.a2) + 33'(i_item.b2);
            r1_n2x  <= 34'(n1_axw) - 34'(i_item.b0);
            r1_n2y  <= 34'(n1_ayh) - 34'(i_item.b1);
            r1_a0   <= i_item.a0;
            r1_a1   <= i_item.a1;
            r1_a2   <= i_item.a2;
            r1_b0   <= i_item.b0;
            r1_b1   <= i_item.b1;
            r1_b2   <= i_item.b2;
            r1_b3   <= i_item.b3;
            r1_rr   <= !(n1_axw < 33'(i_item.b0) || 33'(i_item.a0) > n1_bxw ||
                         n1_ayh < 33'(i_item.b1) || 33'(i_item.a1) > n1_byh);
        end
    end

    // stage 2: closest point, square operands, slab bounds
    logic signed [32:0] w2_mx, w2_my, w2_qx, w2_qy;
    logic signed [33:0] w2_cdx, w2_cdy, w2_sqa, w2_sqb, w2_sqr;
    logic signed [34:0] w2_m1x, w2_m2x, w2_m1y, w2_m2y;
    logic        [31:0] w2_adx, w2_ady;
    logic               w2_zxm, w2_zym;

    assign w2_mx  = (33'(r1_b0) < r1_axw) ? 33'(r1_b0) : r1_axw;
    assign w2_my  = (33'(r1_b1) < r1_ayh) ? 33'(r1_b1) : r1_ayh;
    assign w2_qx  = (w2_mx > 33'(r1_a0)) ? w2_mx : 33'(r1_a0);
    assign w2_qy  = (w2_my > 33'(r1_a1)) ? w2_my : 33'(r1_a1);
    assign w2_cdx = 34'(r1_b0) - 34'(w2_qx);
    assign w2_cdy = 34'(r1_b1) - 34'(w2_qy);

    always_comb begin
        case (r1_op)
            OP_RC: begin
                w2_sqa = w2_cdx; w2_sqb = w2_cdy; w2_sqr = 34'(r1_b2);
            end
            OP_CC: begin
                w2_sqa = 34'(r1_d0); w2_sqb = 34'(r1_d1); w2_sqr = 34'(r1_rsum);
            end
            default: begin
                w2_sqa = 34'(r1_d0); w2_sqb = 34'(r1_d1); w2_sqr = 34'(r1_a2);
            end
        endcase
    end

    assign w2_zxm = (r1_b2 == '0) &&
        ((r1_d0 > 0 && r1_n2x > 0) || (r1_d0 < 0 && r1_n2x < 0));
    assign w2_zym = (r1_b3 == '0) &&
        ((r1_d1 > 0 && r1_n2y > 0) || (r1_d1 < 0 && r1_n2y < 0));
    assign w2_m1x = (r1_b2 < 0) ? -35'(r1_d0)  : 35'(r1_d0);
    assign w2_m2x = (r1_b2 < 0) ? -35'(r1_n2x) : 35'(r1_n2x);
    assign w2_m1y = (r1_b3 < 0) ? -35'(r1_d1)  : 35'(r1_d1);
    assign w2_m2y = (r1_b3 < 0) ? -35'(r1_n2y) : 35'(r1_n2y);
    assign w2_adx = (r1_b2 < 0) ? $unsigned(-r1_b2) : $unsigned(r1_b2);
    assign w2_ady = (r1_b3 < 0) ? $unsigned(-r1_b3) : $unsigned(r1_b3);

    logic signed [33:0] r2_sqa, r2_sqb, r2_sqr;
    logic signed [34:0] r2_enx, r2_exx, r2_eny, r2_exy;
    logic        [31:0] r2_adx, r2_ady;
    logic               r2_limx, r2_limy, r2_zm, r2_rr;
    logic signed [32:0] r2_ox, r2_oy;
    logic signed [31:0] r2_dx, r2_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op   <= r1_op;
            r2_sqa  <= w2_sqa;
            r2_sqb  <= w2_sqb;
            r2_sqr  <= w2_sqr;
            r2_enx  <= (w2_m1x < w2_m2x) ? w2_m1x : w2_m2x;
            r2_exx  <= (w2_m1x < w2_m2x) ? w2_m2x : w2_m1x;
            r2_eny  <= (w2_m1y < w2_m2y) ? w2_m1y : w2_m2y;
            r2_exy  <= (w2_m1y < w2_m2y) ? w2_m2y : w2_m1y;
            r2_adx  <= w2_adx;
            r2_ady  <= w2_ady;
            r2_limx <= (r1_b2 != '0);
            r2_limy <= (r1_b3 != '0);
            r2_zm   <= w2_zxm || w2_zym;
            r2_rr   <= r1_rr;
            r2_ox   <= r1_d0;
            r2_oy   <= r1_d1;
            r2_dx   <= r1_b2;
            r2_dy   <= r1_b3;
        end
    end

    // stage 3: products
    logic signed [32:0] w3_sadx, w3_sady;
    assign w3_sadx = $signed({1'b0, r2_adx});
    assign w3_sady = $signed({1'b0, r2_ady});

    logic signed [67:0] r3_pa, r3_pb, r3_pr, r3_q1, r3_q2, r3_q3, r3_q4;
    logic signed [64:0] r3_oxdx, r3_oydy, r3_oxdy, r3_oydx;
    logic signed [63:0] r3_dxx, r3_dyy;
    logic               r3_exxn, r3_exyn, r3_limx, r3_limy, r3_zm, r3_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_op   <= r2_op;
            r3_pa   <= 68'(r2_sqa) * 68'(r2_sqa);
            r3_pb   <= 68'(r2_sqb) * 68'(r2_sqb);
            r3_pr   <= 68'(r2_sqr) * 68'(r2_sqr);
            r3_q1   <= 68'(r2_enx) * 68'(w3_sady);
            r3_q2   <= 68'(r2_exy) * 68'(w3_sadx);
            r3_q3   <= 68'(r2_eny) * 68'(w3_sadx);
            r3_q4   <= 68'(r2_exx) * 68'(w3_sady);
            r3_oxdx <= 65'(r2_ox) * 65'(r2_dx);
            r3_oydy <= 65'(r2_oy) * 65'(r2_dy);
            r3_oxdy <= 65'(r2_ox) * 65'(r2_dy);
            r3_oydx <= 65'(r2_oy) * 65'(r2_dx);
            r3_dxx  <= 64'(r2_dx) * 64'(r2_dx);
            r3_dyy  <= 64'(r2_dy) * 64'(r2_dy);
            r3_exxn <= (r2_exx < 0);
            r3_exyn <= (r2_exy < 0);
            r3_limx <= r2_limx;
            r3_limy <= r2_limy;
            r3_zm   <= r2_zm;
            r3_rr   <= r2_rr;
        end
    end

    // stage 4: sums of products, slab decision
    logic signed [65:0] w4_dot, w4_cr;
    logic               w4_rymiss;

    assign w4_dot = 66'(r3_oxdx) + 66'(r3_oydy);
    assign w4_cr  = 66'(r3_oxdy) - 66'(r3_oydx);
    assign w4_rymiss = r3_zm || (r3_limx && r3_exxn) || (r3_limy && r3_exyn) ||
        (r3_limx && r3_limy && (r3_q1 > r3_q2 || r3_q3 > r3_q4));

    logic [67:0] r4_d2, r4_r2;
    logic [65:0] r4_crm;
    logic [63:0] r4_dd;
    logic        r4_dotn, r4_ry, r4_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_op   <= r3_op;
            r4_d2   <= $unsigned(r3_pa) + $unsigned(r3_pb);
            r4_r2   <= $unsigned(r3_pr);
            r4_crm  <= (w4_cr < 0) ? $unsigned(-w4_cr) : $unsigned(w4_cr);
            r4_dd   <= $unsigned(r3_dxx) + $unsigned(r3_dyy);
            r4_dotn <= (w4_dot < 0);
            r4_ry   <= !w4_rymiss;
            r4_rr   <= r3_rr;
        end
    end

    // stage 5: distance compares, partial products of the tangent test
    logic [32:0] w5_ch, w5_cl;
    logic [31:0] w5_rh, w5_rl, w5_dh, w5_dl;
    assign w5_ch = r4_crm[65:33];
    assign w5_cl = r4_crm[32:0];
    assign w5_rh = r4_r2[63:32];
    assign w5_rl = r4_r2[31:0];
    assign w5_dh = r4_dd[63:32];
    assign w5_dl = r4_dd[31:0];

    logic [65:0] r5_hh, r5_hl, r5_ll;
    logic [63:0] r5_phh, r5_phl, r5_plh, r5_pll;
    logic        r5_lt, r5_le, r5_dz, r5_dotn, r5_ry, r5_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_op   <= r4_op;
            r5_hh   <= 66'(w5_ch) * 66'(w5_ch);
            r5_hl   <= 66'(w5_ch) * 66'(w5_cl);
            r5_ll   <= 66'(w5_cl) * 66'(w5_cl);
            r5_phh  <= 64'(w5_rh) * 64'(w5_dh);
            r5_phl  <= 64'(w5_rh) * 64'(w5_dl);
            r5_plh  <= 64'(w5_rl) * 64'(w5_dh);
            r5_pll  <= 64'(w5_rl) * 64'(w5_dl);
            r5_lt   <= (r4_d2 < r4_r2);
            r5_le   <= (r4_d2 <= r4_r2);
            r5_dz   <= (r4_dd == '0);
            r5_dotn <= r4_dotn;
            r5_ry   <= r4_ry;
            r5_rr   <= r4_rr;
        end
    end

    // stage 6: assemble the wide tangent terms
    logic [131:0] r6_lhs, r6_rhs;
    logic         r6_lt, r6_le, r6_dz, r6_dotn, r6_ry, r6_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_op   <= r5_op;
            r6_lhs  <= (132'(r5_hh) << 66) + (132'(r5_hl) << 34) + 132'(r5_ll);
            r6_rhs  <= (132'(r5_phh) << 64) + (132'(r5_phl) << 32) +
                       (132'(r5_plh) << 32) + 132'(r5_pll);
            r6_lt   <= r5_lt;
            r6_le   <= r5_le;
            r6_dz   <= r5_dz;
            r6_dotn <= r5_dotn;
            r6_ry   <= r5_ry;
            r6_rr   <= r5_rr;
        end
    end

    // stage 7: select the answer into the output register
    logic n_hit;
    always_comb begin
        case (r6_op)
            OP_RR:   n_hit = r6_rr;
            OP_RC,
            OP_CC:   n_hit = r6_lt;
            OP_RY:   n_hit = r6_ry;
            OP_CY:   n_hit = r6_le || (!r6_dz && !r6_dotn && (r6_lhs <= r6_rhs));
            default: n_hit = 1'b0;
        endcase
    end

    logic r_hit;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:1], o_pop};
        end
    end

    // the output register is the last valid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[6];
        end
    end

    assign o_valid = r_out_v;
    assign o_hit   = r_hit;

endmodule

### rtl/shape_pair_overlap_test.sv
// Shape pair overlap test, top level.
// Channels: one request in (two shapes: kind plus four Q16.16 parameters each),
// one hit flag out, both with valid/ready; a request is taken when valid and
// ready are high at a rising edge of i_clk.
// Shapes: rectangle (x, y, w, h), circle (cx, cy, r), ray (ox, oy, dx, dy).
// Throughput: one request per cycle while the receiver does not stall; the
// back end is a seven-register pipeline (sums, clamp and slab bounds, products,
// sums of products, compares and partial products, wide tangent terms, output
// register). A request accepted into the queue is popped into the first stage
// and carried through the later stages to the output register, raising o_valid.
// A four-entry queue sits between the classifying front end and the pipeline;
// o_ready falls only when it is full.
// Stall: while o_valid is high and i_out_ready low the pipeline holds and
// o_hit stays put; the front end keeps taking requests until the queue fills.
// Reset: i_rst_n low at a clock edge empties the queue and the pipeline.
// Depends on spo_pkg, spo_front, spo_fifo, spo_back.
module shape_pair_overlap_test import spo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [1:0]  i_kind_a,
    input  logic signed [31:0] i_a_p0,
    input  logic signed [31:0] i_a_p1,
    input  logic signed [31:0] i_a_p2,
    input  logic signed [31:0] i_a_p3,
    input  logic        [1:0]  i_kind_b,
    input  logic signed [31:0] i_b_p0,
    input  logic signed [31:0] i_b_p1,
    input  logic signed [31:0] i_b_p2,
    input  logic signed [31:0] i_b_p3,
    output logic               o_valid,
    input  logic               i_out_ready,
    output logic               o_hit
);

    t_item front_item;
    t_item head_item;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    spo_front u_front (
        .i_kind_a (i_kind_a),
        .i_a_p0   (i_a_p0),
        .i_a_p1   (i_a_p1),
        .i_a_p2   (i_a_p2),
        .i_a_p3   (i_a_p3),
        .i_kind_b (i_kind_b),
        .i_b_p0   (i_b_p0),
        .i_b_p1   (i_b_p1),
        .i_b_p2   (i_b_p2),
        .i_b_p3   (i_b_p3),
        .o_item   (front_item)
    );

    spo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    spo_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_item  (head_item),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_out_ready),
        .o_hit   (o_hit)
    );

    assign o_ready = !q_full;

endmodule
